### rtl/gpioe_pkg.sv
`default_nettype none

package gpioe_pkg;

  localparam int NUM_BANKS = 64;
  localparam int IRQ_PINS  = 12;
  localparam int BANK_W    = $clog2(NUM_BANKS);

  // item commands
  localparam logic [1:0] CMD_READ   = 2'd0;
  localparam logic [1:0] CMD_WRITE  = 2'd1;
  localparam logic [1:0] CMD_SAMPLE = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;

  // bank register regions, address bits [10:6]
  localparam logic [4:0] REG_IN_LVL  = 5'h00;
  localparam logic [4:0] REG_MUX_EN  = 5'h01;
  localparam logic [4:0] REG_OUT_EN  = 5'h02;
  localparam logic [4:0] REG_OUT_LVL = 5'h03;
  localparam logic [4:0] REG_PULL_EN = 5'h12;
  localparam logic [4:0] REG_PSEL_LO = 5'h13;
  localparam logic [4:0] REG_PSEL_HI = 5'h17;

  // word registers, exact byte addresses
  localparam logic [10:0] ADDR_USB_MODE   = 11'h10c;
  localparam logic [10:0] ADDR_PIN_SHARE  = 11'h200;
  localparam logic [10:0] ADDR_IRQ_TYPE   = 11'h300;
  localparam logic [10:0] ADDR_IRQ_STATUS = 11'h304;
  localparam logic [10:0] ADDR_IRQ_MASK   = 11'h308;

  localparam logic [1:0] TYPE_RISING  = 2'b11;
  localparam logic [1:0] TYPE_FALLING = 2'b10;

  // one memory row holds every byte register of a bank
  typedef struct packed {
    logic [7:0] in_lvl;
    logic [7:0] mux_en;
    logic [7:0] out_en;
    logic [7:0] out_lvl;
    logic [7:0] pull_en;
    logic [7:0] psel_lo;
    logic [7:0] psel_hi;
  } row_t;

endpackage

`default_nettype wire

### rtl/gpioe_if.sv
`default_nettype none

interface gpioe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [10:0] address;
  logic [31:0] write_data;
  logic [5:0]  pad_bank;
  logic [7:0]  pad_bits;

  modport source (output valid, command, address, write_data, pad_bank, pad_bits,
                  input ready);
  modport sink   (input valid, command, address, write_data, pad_bank, pad_bits,
                  output ready);
  modport mon    (input valid, ready, command, address, write_data, pad_bank, pad_bits);
endinterface

interface gpioe_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        irq_line;
  logic [5:0]  drive_bank;
  logic [7:0]  drive_level;
  logic [7:0]  drive_enable;

  modport source (output valid, read_data, irq_line, drive_bank, drive_level, drive_enable,
                  input ready);
  modport sink   (input valid, read_data, irq_line, drive_bank, drive_level, drive_enable,
                  output ready);
  modport mon    (input valid, ready, read_data, irq_line, drive_bank, drive_level,
                  drive_enable);
endinterface

`default_nettype wire

### rtl/gpio_controller_edge_irq_top.sv
`default_nettype none

// GPIO controller with edge interrupts. Each item (bus read, bus write or pad
// sample) gives exactly one result: read data, the interrupt line after the
// item's update, and the drive level and enable of the bank it touched. One
// item is taken every cycle unless the output stalls; results are registered.
// The per-bank byte registers live in one bank-indexed memory with a registered
// read; each item does one read-modify-write of its bank's row, and a row
// written back in the same cycle as the next read is forwarded. Rows come out
// of reset as zero through per-row valid bits, so there is no clearing pass and
// the block is ready straight after reset.
module gpio_controller_edge_irq_top
  import gpioe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  gpioe_in_if.sink    in_ch,
  gpioe_out_if.source out_ch
);

  logic              in_accept;
  logic              commit;
  logic [5:0]        in_dbank;
  logic [BANK_W-1:0] in_idx;

  // stage 1: item waiting on its row read
  logic              s1_vld_r;
  logic [1:0]        s1_cmd_r;
  logic [10:0]       s1_addr_r;
  logic [31:0]       s1_wdata_r;
  logic [5:0]        s1_pbank_r;
  logic [7:0]        s1_pbits_r;
  logic [5:0]        s1_dbank;
  logic [BANK_W-1:0] s1_idx;
  logic              s1_row_ok;
  logic [4:0]        s1_region;

  row_t              mem [NUM_BANKS];
  row_t              mem_rd_r;
  logic              row_vld_r;
  logic              fwd_hit_r;
  row_t              fwd_row_r;
  logic [NUM_BANKS-1:0] row_vld_bits_r;
  row_t              cur_row;
  row_t              row_nxt;

  logic [31:0]          usb_mode_r, usb_mode_nxt;
  logic [31:0]          pin_share_r, pin_share_nxt;
  logic [31:0]          irq_type_r, irq_type_nxt;
  logic [IRQ_PINS-1:0]  irq_status_r, irq_status_nxt;
  logic [IRQ_PINS-1:0]  irq_mask_r, irq_mask_nxt;
  logic [IRQ_PINS-1:0]  prev_pins_r, prev_pins_nxt;
  logic [31:0]          rdata;
  logic                 irq_nxt;

  logic        out_vld_r;
  logic [31:0] out_rdata_r;
  logic        out_irq_r;
  logic [5:0]  out_dbank_r;
  logic [7:0]  out_dlvl_r;
  logic [7:0]  out_den_r;

  assign commit       = s1_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !s1_vld_r || commit;
  assign in_accept    = in_ch.valid && in_ch.ready;

  assign in_dbank = (in_ch.command == CMD_SAMPLE) ? in_ch.pad_bank : in_ch.address[5:0];
  assign in_idx   = in_dbank[BANK_W-1:0];

  assign s1_dbank  = (s1_cmd_r == CMD_SAMPLE) ? s1_pbank_r : s1_addr_r[5:0];
  assign s1_idx    = s1_dbank[BANK_W-1:0];
  assign s1_row_ok = {1'b0, s1_dbank} < 7'(NUM_BANKS);
  assign s1_region = s1_addr_r[10:6];

  // never-written rows read as zero; a row written at the read edge is forwarded
  assign cur_row = fwd_hit_r ? fwd_row_r : (row_vld_r ? mem_rd_r : '0);

  always_comb begin
    row_nxt        = cur_row;
    rdata          = '0;
    usb_mode_nxt   = usb_mode_r;
    pin_share_nxt  = pin_share_r;
    irq_type_nxt   = irq_type_r;
    irq_status_nxt = irq_status_r;
    irq_mask_nxt   = irq_mask_r;
    prev_pins_nxt  = prev_pins_r;
    case (s1_cmd_r)
      CMD_READ: begin
        if (s1_row_ok) begin
          case (s1_region)
            REG_IN_LVL:  rdata = {24'd0, cur_row.in_lvl};
            REG_MUX_EN:  rdata = {24'd0, cur_row.mux_en};
            REG_OUT_EN:  rdata = {24'd0, cur_row.out_en};
            REG_OUT_LVL: rdata = {24'd0, cur_row.out_lvl};
            REG_PULL_EN: rdata = {24'd0, cur_row.pull_en};
            REG_PSEL_LO: rdata = {24'd0, cur_row.psel_lo};
            REG_PSEL_HI: rdata = {24'd0, cur_row.psel_hi};
            default: ;
          endcase
        end
        case (s1_addr_r)
          ADDR_USB_MODE:   rdata = usb_mode_r;
          ADDR_PIN_SHARE:  rdata = pin_share_r;
          ADDR_IRQ_TYPE:   rdata = irq_type_r;
          ADDR_IRQ_STATUS: rdata = 32'(irq_status_r);
          ADDR_IRQ_MASK:   rdata = 32'(irq_mask_r);
          default: ;
        endcase
      end
      CMD_WRITE: begin
        if (s1_row_ok) begin
          case (s1_region)
            REG_IN_LVL:  row_nxt.in_lvl  = s1_wdata_r[7:0];
            REG_MUX_EN:  row_nxt.mux_en  = s1_wdata_r[7:0];
            REG_OUT_EN:  row_nxt.out_en  = s1_wdata_r[7:0];
            REG_OUT_LVL: row_nxt.out_lvl = s1_wdata_r[7:0];
            REG_PULL_EN: row_nxt.pull_en = s1_wdata_r[7:0];
            REG_PSEL_LO: row_nxt.psel_lo = s1_wdata_r[7:0];
            REG_PSEL_HI: row_nxt.psel_hi = s1_wdata_r[7:0];
            default: ;
          endcase
        end
        case (s1_addr_r)
          ADDR_USB_MODE:   usb_mode_nxt   = s1_wdata_r;
          ADDR_PIN_SHARE:  pin_share_nxt  = s1_wdata_r;
          ADDR_IRQ_TYPE:   irq_type_nxt   = s1_wdata_r;
          ADDR_IRQ_STATUS: irq_status_nxt = irq_status_r & ~s1_wdata_r[IRQ_PINS-1:0];
          ADDR_IRQ_MASK:   irq_mask_nxt   = s1_wdata_r[IRQ_PINS-1:0];
          default: ;
        endcase
      end
      CMD_SAMPLE: begin
        if (s1_row_ok) begin
          row_nxt.in_lvl = s1_pbits_r;
          // interrupt pin i sits in bank i/8, bit i%8
          for (int i = 0; i < IRQ_PINS; i++) begin
            if (s1_pbank_r == 6'(i / 8)) begin
              if ((irq_type_r[2*i +: 2] == TYPE_RISING && !prev_pins_r[i] &&
                   s1_pbits_r[i % 8]) ||
                  (irq_type_r[2*i +: 2] == TYPE_FALLING && prev_pins_r[i] &&
                   !s1_pbits_r[i % 8])) begin
                irq_status_nxt[i] = 1'b1;
              end
              prev_pins_nxt[i] = s1_pbits_r[i % 8];
            end
          end
        end
      end
      default: ;
    endcase
    irq_nxt = |(irq_status_nxt & ~irq_mask_nxt);
  end

  // bank memory: registered read on accept, write-back on commit
  always_ff @(posedge clk) begin
    if (commit && s1_row_ok) begin
      mem[s1_idx] <= row_nxt;
    end
    if (in_accept) begin
      mem_rd_r  <= mem[in_idx];
      fwd_row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cmd_r   <= in_ch.command;
      s1_addr_r  <= in_ch.address;
      s1_wdata_r <= in_ch.write_data;
      s1_pbank_r <= in_ch.pad_bank;
      s1_pbits_r <= in_ch.pad_bits;
    end
    if (commit) begin
      out_rdata_r <= rdata;
      out_irq_r   <= irq_nxt;
      out_dbank_r <= s1_dbank;
      out_dlvl_r  <= s1_row_ok ? row_nxt.out_lvl : 8'd0;
      out_den_r   <= s1_row_ok ? row_nxt.out_en : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r       <= 1'b0;
      out_vld_r      <= 1'b0;
      row_vld_r      <= 1'b0;
      fwd_hit_r      <= 1'b0;
      row_vld_bits_r <= '0;
      usb_mode_r     <= '0;
      pin_share_r    <= '0;
      irq_type_r     <= '0;
      irq_status_r   <= '0;
      irq_mask_r     <= '0;
      prev_pins_r    <= '0;
    end else begin
      if (in_accept) begin
        s1_vld_r  <= 1'b1;
        row_vld_r <= row_vld_bits_r[in_idx];
        fwd_hit_r <= commit && s1_row_ok && (s1_idx == in_idx);
      end else if (commit) begin
        s1_vld_r <= 1'b0;
      end
      if (commit) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
      if (commit) begin
        if (s1_row_ok) begin
          row_vld_bits_r[s1_idx] <= 1'b1;
        end
        usb_mode_r   <= usb_mode_nxt;
        pin_share_r  <= pin_share_nxt;
        irq_type_r   <= irq_type_nxt;
        irq_status_r <= irq_status_nxt;
        irq_mask_r   <= irq_mask_nxt;
        prev_pins_r  <= prev_pins_nxt;
      end
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.read_data    = out_rdata_r;
  assign out_ch.irq_line     = out_irq_r;
  assign out_ch.drive_bank   = out_dbank_r;
  assign out_ch.drive_level  = out_dlvl_r;
  assign out_ch.drive_enable = out_den_r;

endmodule

`default_nettype wire

### rtl/gpioe_checker.sv
`default_nettype none

module gpioe_checker (
  input logic         clk,
  input logic         rst_n,
  gpioe_in_if.sink    in_ch,
  gpioe_out_if.source out_ch
);

  // nothing comes out of reset with a result pending
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result valid straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("result withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=>
      $stable(out_ch.read_data) && $stable(out_ch.irq_line) &&
      $stable(out_ch.drive_bank) && $stable(out_ch.drive_level) &&
      $stable(out_ch.drive_enable))
    else $error("stalled result changed");

  // a result stream starting from empty stems from an item accepted at the input
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(in_ch.valid && in_ch.ready, 2))
    else $error("result appeared without a matching item");

endmodule

bind gpio_controller_edge_irq_top gpioe_checker u_gpioe_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

`default_nettype wire

### sim/tb_top.sv
module tb_top
  import gpioe_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // region code that matches no bank register (bank offset out of range)
  localparam logic [4:0] REGION_NONE = 5'h1f;

  typedef struct packed {
    logic [1:0]  command;
    logic [10:0] address;
    logic [31:0] write_data;
    logic [5:0]  pad_bank;
    logic [7:0]  pad_bits;
  } gpio_cmd_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_line;
    logic [5:0]  drive_bank;
    logic [7:0]  drive_level;
    logic [7:0]  drive_enable;
  } gpio_resp_t;

  logic clk;
  logic rst_n;

  gpioe_in_if  in_ch();
  gpioe_out_if out_ch();

  gpio_controller_edge_irq_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow copy of the controller state
  row_t                 shadow_rows [NUM_BANKS];
  logic [31:0]          usb_mode_q    = '0;
  logic [31:0]          pin_share_q   = '0;
  logic [31:0]          irq_type_q    = '0;
  logic [IRQ_PINS-1:0]  irq_status_q  = '0;
  logic [IRQ_PINS-1:0]  irq_mask_q    = '0;
  logic [IRQ_PINS-1:0]  prev_pins_q   = '0;

  gpio_resp_t pending_q [$];

  int error_count   = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_left     = 0;
  int n_reads       = 0;
  int n_writes      = 0;
  int n_samples     = 0;
  int n_irq_high    = 0;
  int input_stalls  = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("gpio_controller_edge_irq_top test failed");
    $finish;
  end

  task automatic flag_error(input string msg);
    if (error_count < 40)
      $display("MISMATCH @%0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic gpio_cmd_t gpio_op(input logic [1:0] cmd, input logic [10:0] addr,
                                        input logic [31:0] wdata, input logic [5:0] pbank,
                                        input logic [7:0] pbits);
    gpio_cmd_t c;
    c.command    = cmd;
    c.address    = addr;
    c.write_data = wdata;
    c.pad_bank   = pbank;
    c.pad_bits   = pbits;
    return c;
  endfunction

  // works out the result of one item and updates the shadow state
  task automatic predict_result(input gpio_cmd_t c, output gpio_resp_t r);
    logic [5:0] off;
    logic [4:0] region;
    logic [1:0] edge_type;
    int         pin;
    row_t       row;
    off    = c.address[5:0];
    region = (int'(off) < NUM_BANKS) ? c.address[10:6] : REGION_NONE;
    row    = shadow_rows[off];
    r      = '0;
    r.drive_bank = off;
    case (c.command)
      CMD_READ: begin
        n_reads++;
        case (region)
          REG_IN_LVL:  r.read_data = 32'(row.in_lvl);
          REG_MUX_EN:  r.read_data = 32'(row.mux_en);
          REG_OUT_EN:  r.read_data = 32'(row.out_en);
          REG_OUT_LVL: r.read_data = 32'(row.out_lvl);
          REG_PULL_EN: r.read_data = 32'(row.pull_en);
          REG_PSEL_LO: r.read_data = 32'(row.psel_lo);
          REG_PSEL_HI: r.read_data = 32'(row.psel_hi);
          default: begin
            case (c.address)
              ADDR_USB_MODE:   r.read_data = usb_mode_q;
              ADDR_PIN_SHARE:  r.read_data = pin_share_q;
              ADDR_IRQ_TYPE:   r.read_data = irq_type_q;
              ADDR_IRQ_STATUS: r.read_data = 32'(irq_status_q);
              ADDR_IRQ_MASK:   r.read_data = 32'(irq_mask_q);
              default:         r.read_data = '0;
            endcase
          end
        endcase
      end
      CMD_WRITE: begin
        n_writes++;
        case (region)
          REG_IN_LVL:  row.in_lvl  = c.write_data[7:0];
          REG_MUX_EN:  row.mux_en  = c.write_data[7:0];
          REG_OUT_EN:  row.out_en  = c.write_data[7:0];
          REG_OUT_LVL: row.out_lvl = c.write_data[7:0];
          REG_PULL_EN: row.pull_en = c.write_data[7:0];
          REG_PSEL_LO: row.psel_lo = c.write_data[7:0];
          REG_PSEL_HI: row.psel_hi = c.write_data[7:0];
          default: begin
            case (c.address)
              ADDR_USB_MODE:   usb_mode_q   = c.write_data;
              ADDR_PIN_SHARE:  pin_share_q  = c.write_data;
              ADDR_IRQ_TYPE:   irq_type_q   = c.write_data;
              ADDR_IRQ_STATUS: irq_status_q = irq_status_q & ~c.write_data[IRQ_PINS-1:0];
              ADDR_IRQ_MASK:   irq_mask_q   = c.write_data[IRQ_PINS-1:0];
              default: ;
            endcase
          end
        endcase
        if (int'(off) < NUM_BANKS)
          shadow_rows[off] = row;
      end
      CMD_SAMPLE: begin
        n_samples++;
        r.drive_bank = c.pad_bank;
        if (int'(c.pad_bank) < NUM_BANKS) begin
          shadow_rows[c.pad_bank].in_lvl = c.pad_bits;
          for (int p = 0; p < 8; p++) begin
            pin = int'(c.pad_bank) * 8 + p;
            if (pin < IRQ_PINS) begin
              edge_type = irq_type_q[2*pin +: 2];
              if ((edge_type == TYPE_RISING && !prev_pins_q[pin] && c.pad_bits[p]) ||
                  (edge_type == TYPE_FALLING && prev_pins_q[pin] && !c.pad_bits[p]))
                irq_status_q[pin] = 1'b1;
              prev_pins_q[pin] = c.pad_bits[p];
            end
          end
        end
      end
      default: ;
    endcase
    r.irq_line = |(irq_status_q & ~irq_mask_q);
    if (r.irq_line)
      n_irq_high++;
    if (int'(r.drive_bank) < NUM_BANKS) begin
      r.drive_level  = shadow_rows[r.drive_bank].out_lvl;
      r.drive_enable = shadow_rows[r.drive_bank].out_en;
    end
  endtask

  // valid is only ever assigned once per time step; it stays high between
  // back-to-back items
  task automatic send_item(input gpio_cmd_t c);
    gpio_resp_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.command    <= c.command;
    in_ch.address    <= c.address;
    in_ch.write_data <= c.write_data;
    in_ch.pad_bank   <= c.pad_bank;
    in_ch.pad_bits   <= c.pad_bits;
    @(posedge clk);
    while (in_ch.ready !== 1'b1)
      @(posedge clk);
    predict_result(c, want);
    pending_q.push_back(want);
  endtask

  // result sink: random stalls, plus long hold-offs on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin : check_results
    gpio_resp_t want;
    if (rst_n && in_ch.valid === 1'b1 && in_ch.ready !== 1'b1)
      input_stalls++;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_q.size() == 0) begin
        flag_error("result with no item outstanding");
      end else begin
        want = pending_q.pop_front();
        if (out_ch.read_data !== want.read_data)
          flag_error($sformatf("read_data %h, want %h", out_ch.read_data, want.read_data));
        if (out_ch.irq_line !== want.irq_line)
          flag_error($sformatf("irq_line %b, want %b", out_ch.irq_line, want.irq_line));
        if (out_ch.drive_bank !== want.drive_bank)
          flag_error($sformatf("drive_bank %0d, want %0d", out_ch.drive_bank,
                               want.drive_bank));
        if (out_ch.drive_level !== want.drive_level)
          flag_error($sformatf("drive_level %h, want %h (bank %0d)", out_ch.drive_level,
                               want.drive_level, want.drive_bank));
        if (out_ch.drive_enable !== want.drive_enable)
          flag_error($sformatf("drive_enable %h, want %h (bank %0d)", out_ch.drive_enable,
                               want.drive_enable, want.drive_bank));
      end
    end
  end

  task automatic test_bank_regs();
    send_item(gpio_op(CMD_READ,  {REG_OUT_LVL, 6'd0},  32'h0,        6'd0, 8'h00));
    send_item(gpio_op(CMD_WRITE, {REG_OUT_EN, 6'd63},  32'hffffffff, 6'd0, 8'h00));
    send_item(gpio_op(CMD_WRITE, {REG_OUT_LVL, 6'd63}, 32'h000000a5, 6'd0, 8'h00));
    send_item(gpio_op(CMD_READ,  {REG_OUT_EN, 6'd63},  32'h0,        6'd0, 8'h00));
    send_item(gpio_op(CMD_WRITE, {REG_MUX_EN, 6'd0},   32'h000000ff, 6'd0, 8'h00));
    send_item(gpio_op(CMD_WRITE, {REG_PULL_EN, 6'd0},  32'h0000005a, 6'd0, 8'h00));
    send_item(gpio_op(CMD_WRITE, {REG_PSEL_HI, 6'd63}, 32'h00000081, 6'd0, 8'h00));
    send_item(gpio_op(CMD_READ,  {REG_PSEL_HI, 6'd63}, 32'h0,        6'd0, 8'h00));
    // bus write to the input levels: stored, no edge detection
    send_item(gpio_op(CMD_WRITE, {REG_IN_LVL, 6'd1},   32'h000000ff, 6'd0, 8'h00));
  endtask

  task automatic test_word_regs();
    send_item(gpio_op(CMD_WRITE, ADDR_USB_MODE, 32'hffffffff, 6'd0, 8'h00));
    send_item(gpio_op(CMD_READ,  ADDR_USB_MODE, 32'h0,        6'd0, 8'h00));
  endtask

  task automatic test_edge_irq();
    // pin 0 rising, pin 1 falling, pin 2 type 1, pin 3 type 0, pin 11 rising
    send_item(gpio_op(CMD_WRITE,  ADDR_IRQ_TYPE,   32'hffc0001b, 6'd0, 8'h00));
    send_item(gpio_op(CMD_SAMPLE, 11'h0,           32'h0,        6'd0, 8'hff));
    send_item(gpio_op(CMD_SAMPLE, 11'h0,           32'h0,        6'd1, 8'h08));
    send_item(gpio_op(CMD_SAMPLE, 11'h0,           32'h0,        6'd0, 8'h00));
    send_item(gpio_op(CMD_READ,   ADDR_IRQ_STATUS, 32'h0,        6'd0, 8'h00));
    send_item(gpio_op(CMD_WRITE,  ADDR_IRQ_MASK,   32'hffffffff, 6'd0, 8'h00));
    send_item(gpio_op(CMD_WRITE,  ADDR_IRQ_STATUS, 32'h00000001, 6'd0, 8'h00));
    send_item(gpio_op(CMD_WRITE,  ADDR_IRQ_MASK,   32'h00000000, 6'd0, 8'h00));
    send_item(gpio_op(CMD_WRITE,  ADDR_IRQ_STATUS, 32'hffffffff, 6'd0, 8'h00));
  endtask

  task automatic test_unmapped();
    send_item(gpio_op(CMD_READ,   11'h10d, 32'h0,        6'd0,  8'h00));
    send_item(gpio_op(CMD_WRITE,  11'h400, 32'hffffffff, 6'd0,  8'h00));
    send_item(gpio_op(CMD_READ,   11'h400, 32'h0,        6'd0,  8'h00));
    send_item(gpio_op(CMD_NOP,    {REG_OUT_EN, 6'd63}, 32'hffffffff, 6'd63, 8'hff));
    send_item(gpio_op(CMD_READ,   11'h7ff, 32'h0,        6'd0,  8'h00));
    // pads of a bank with no interrupt pins
    send_item(gpio_op(CMD_SAMPLE, 11'h0,   32'h0,        6'd63, 8'hff));
  endtask

  task automatic test_random(input int idle, input int stall, input int count);
    gpio_cmd_t c;
    int        pick;
    send_idle_pct = idle;
    stall_pct     = stall;
    repeat (count) begin
      c.write_data = $urandom();
      c.pad_bank   = 6'($urandom_range(63));
      c.pad_bits   = 8'($urandom_range(255));
      pick = $urandom_range(99);
      c.command = (pick < 30) ? CMD_READ : (pick < 60) ? CMD_WRITE :
                  (pick < 95) ? CMD_SAMPLE : CMD_NOP;
      pick = $urandom_range(99);
      if (pick < 55) begin
        c.address[5:0] = $urandom_range(1) ? 6'($urandom_range(3)) : 6'($urandom_range(63));
        case ($urandom_range(6))
          0: c.address[10:6] = REG_IN_LVL;
          1: c.address[10:6] = REG_MUX_EN;
          2: c.address[10:6] = REG_OUT_EN;
          3: c.address[10:6] = REG_OUT_LVL;
          4: c.address[10:6] = REG_PULL_EN;
          5: c.address[10:6] = REG_PSEL_LO;
          default: c.address[10:6] = REG_PSEL_HI;
        endcase
      end else if (pick < 90) begin
        case ($urandom_range(4))
          0: c.address = ADDR_USB_MODE;
          1: c.address = ADDR_PIN_SHARE;
          2: c.address = ADDR_IRQ_TYPE;
          3: c.address = ADDR_IRQ_STATUS;
          default: c.address = ADDR_IRQ_MASK;
        endcase
      end else begin
        c.address = 11'($urandom_range(2047));
      end
      // single-bit clears and masks keep some interrupts alive
      if ((c.address == ADDR_IRQ_STATUS || c.address == ADDR_IRQ_MASK) && $urandom_range(1))
        c.write_data = 32'h1 << $urandom_range(IRQ_PINS - 1);
      // most pad samples hit the interrupt pins
      if ($urandom_range(99) < 70)
        c.pad_bank = 6'($urandom_range(1));
      send_item(c);
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = 80;
    for (int i = 0; i < 30; i++)
      send_item(gpio_op(i[0] ? CMD_SAMPLE : CMD_WRITE, {REG_OUT_LVL, 6'(i)}, $urandom(),
                        6'($urandom_range(1)), 8'($urandom_range(255))));
  endtask

  initial begin
    foreach (shadow_rows[i])
      shadow_rows[i] = '0;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.command    <= CMD_READ;
    in_ch.address    <= '0;
    in_ch.write_data <= '0;
    in_ch.pad_bank   <= '0;
    in_ch.pad_bits   <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_bank_regs();
    test_word_regs();
    test_edge_irq();
    test_unmapped();
    test_random(0, 0, 130);
    test_random(88, 0, 130);
    test_random(0, 88, 130);
    test_random(27, 27, 130);
    test_backpressure();
    in_ch.valid <= 1'b0;

    while (pending_q.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d reads, %0d writes, %0d pad samples; irq high in %0d results.",
             n_reads, n_writes, n_samples, n_irq_high);
    $display("Input held off for %0d cycles under output back-pressure; %0d errors.",
             input_stalls, error_count);
    if (error_count == 0)
      $display("gpio_controller_edge_irq_top test passed");
    else
      $display("gpio_controller_edge_irq_top test failed");
    $finish;
  end

endmodule

### gpio_controller_edge_irq_top.f
rtl/gpioe_pkg.sv
rtl/gpioe_if.sv
rtl/gpio_controller_edge_irq_top.sv
rtl/gpioe_checker.sv
sim/tb_top.sv
